[hw/rtl/sfd_pkg.sv]
// SLIP frame decoder package: byte codes, result and transaction types.
// No dependencies; imported by the interfaces and all decoder modules.
`default_nettype none

package sfd_pkg;

  localparam int BYTE_W = 8;

  // SLIP special bytes
  localparam logic [BYTE_W-1:0] SYM_END     = 8'hC0;
  localparam logic [BYTE_W-1:0] SYM_ESC     = 8'hDB;
  localparam logic [BYTE_W-1:0] SYM_ESC_END = 8'hDC;
  localparam logic [BYTE_W-1:0] SYM_ESC_ESC = 8'hDD;

  // configuration register map (word addresses)
  localparam logic REG_MAX_LENGTH = 1'b0;
  localparam logic [BYTE_W-1:0] MAX_LENGTH_RST = 8'd32;

  // one result transaction
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic [BYTE_W-1:0] frame_length;
    logic              overflowed;
    logic              last_of_run;
  } res_t;

  // results produced by one input byte (zero, one or two)
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

endpackage

`default_nettype wire

[hw/rtl/sfd_if.sv]
// Valid/ready channel interfaces for raw input bytes and decoded results.
// Depends on sfd_pkg.
`default_nettype none

interface sfd_rx_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              frame_end;
  logic [BYTE_W-1:0] frame_length;
  logic              overflowed;
  logic              last_of_run;

  modport source (output valid, output out_byte, output frame_end, output frame_length,
                  output overflowed, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input frame_end, input frame_length,
                  input overflowed, input last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/slip_frame_decoder_core.sv]
// SLIP frame decoder top level: APB register, decode stage, result queue.
// Depends on sfd_pkg, sfd_if, sfd_decode and sfd_result_fifo.
//
//  channel | dir | handshake           | payload
//  rx      | in  | valid/ready         | rx_byte[7:0]
//  res     | out | valid/ready         | out_byte, frame_end, frame_length,
//          |     |                     | overflowed, last_of_run
//  apb     | in  | psel/penable/pready | paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One input byte per cycle enters the input register while rx.ready is high;
// it is decoded there once two queue entries are free, and its zero, one or
// two results land in a four-entry queue; one result leaves per cycle while
// res.ready is high, so a byte giving two results leaves as two separate
// results and the queue sets the sustained rate. Synchronous reset clears
// framing state, queue and max_length (to 32). A stalled output fills the queue;
// rx.ready drops once fewer than two entries are free while a byte is held.
`default_nettype none

module slip_frame_decoder_core #(
  parameter int unsigned LENGTH_LIMIT = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  sfd_rx_if.sink           rx,
  sfd_res_if.source        res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sfd_pkg::*;

  logic [BYTE_W-1:0] max_length;
  logic              room_two;
  res_pair_t         push;
  res_t              out_res;
  logic              reg_hit;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_MAX_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_length <= pwdata[BYTE_W-1:0];
    end
  end

  assign prdata = reg_hit ? {{(32-BYTE_W){1'b0}}, max_length} : '0;

  // decode stage
  sfd_decode #(
    .LENGTH_LIMIT(LENGTH_LIMIT)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .in_byte   (rx.rx_byte),
    .max_length(max_length),
    .room_two  (room_two),
    .push      (push)
  );

  // result queue
  sfd_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room_two (room_two),
    .out_valid(res.valid),
    .out_ready(res.ready),
    .out_res  (out_res)
  );

  assign res.out_byte     = out_res.out_byte;
  assign res.frame_end    = out_res.frame_end;
  assign res.frame_length = out_res.frame_length;
  assign res.overflowed   = out_res.overflowed;
  assign res.last_of_run  = out_res.last_of_run;

endmodule

`default_nettype wire

[hw/rtl/sfd_decode.sv]
// Input byte register, SLIP framing state and single-pass decode logic.
// Depends on sfd_pkg; feeds result pairs to sfd_result_fifo.
`default_nettype none

module sfd_decode #(
  parameter int unsigned LENGTH_LIMIT = 255
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [sfd_pkg::BYTE_W-1:0] in_byte,
  input  wire logic [sfd_pkg::BYTE_W-1:0] max_length,
  input  wire logic                      room_two,
  output sfd_pkg::res_pair_t             push
);
  import sfd_pkg::*;

  localparam logic [BYTE_W-1:0] LIMIT_CAP = BYTE_W'(LENGTH_LIMIT);

  // input register
  logic              byte_vld;
  logic [BYTE_W-1:0] byte_q;
  // framing state
  logic              esc_pending;
  logic [BYTE_W-1:0] kept_count;
  logic              drop_seen;

  logic              esc_pending_next;
  logic [BYTE_W-1:0] kept_count_next;
  logic              drop_seen_next;
  logic              advance;
  logic [BYTE_W-1:0] lim;
  logic [BYTE_W-1:0] gap;
  logic              room_none;
  logic              room_one;
  res_pair_t         pair;

  assign advance  = byte_vld && room_two;
  assign in_ready = !byte_vld || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (in_ready) begin
      byte_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
    end
  end

  // room left in the current frame
  assign lim       = (max_length > LIMIT_CAP) ? LIMIT_CAP : max_length;
  assign gap       = lim - kept_count;
  assign room_none = (kept_count >= lim);
  assign room_one  = !room_none && (gap == 8'd1);

  // decode one byte
  always_comb begin
    esc_pending_next = esc_pending;
    kept_count_next  = kept_count;
    drop_seen_next   = drop_seen;
    pair             = '0;
    if (esc_pending) begin
      esc_pending_next = 1'b0;
      if (byte_q == SYM_ESC_END || byte_q == SYM_ESC_ESC) begin
        if (room_none) begin
          drop_seen_next = 1'b1;
        end else begin
          kept_count_next         = kept_count + 8'd1;
          pair.num                = 2'd1;
          pair.r0.out_byte        = (byte_q == SYM_ESC_END) ? SYM_END : SYM_ESC;
          pair.r0.last_of_run     = 1'b1;
        end
      end else if (room_none) begin
        drop_seen_next = 1'b1;
      end else if (room_one) begin
        // only the escape byte fits
        kept_count_next     = kept_count + 8'd1;
        drop_seen_next      = 1'b1;
        pair.num            = 2'd1;
        pair.r0.out_byte    = SYM_ESC;
        pair.r0.last_of_run = 1'b1;
      end else begin
        // unknown escape: both bytes pass through
        kept_count_next     = kept_count + 8'd2;
        pair.num            = 2'd2;
        pair.r0.out_byte    = SYM_ESC;
        pair.r1.out_byte    = byte_q;
        pair.r1.last_of_run = 1'b1;
      end
    end else if (byte_q == SYM_END) begin
      pair.num             = 2'd1;
      pair.r0.frame_end    = 1'b1;
      pair.r0.frame_length = kept_count;
      pair.r0.overflowed   = drop_seen;
      pair.r0.last_of_run  = 1'b1;
      kept_count_next      = '0;
      drop_seen_next       = 1'b0;
    end else if (room_none) begin
      drop_seen_next = 1'b1;
    end else if (byte_q == SYM_ESC) begin
      esc_pending_next = 1'b1;
    end else begin
      kept_count_next     = kept_count + 8'd1;
      pair.num            = 2'd1;
      pair.r0.out_byte    = byte_q;
      pair.r0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_pending <= 1'b0;
      kept_count  <= '0;
      drop_seen   <= 1'b0;
    end else if (advance) begin
      esc_pending <= esc_pending_next;
      kept_count  <= kept_count_next;
      drop_seen   <= drop_seen_next;
    end
  end

  always_comb begin
    push = pair;
    if (!advance) begin
      push.num = 2'd0;
    end
  end

  // checks
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (push.num != 2'd0 && push.r0.frame_end) |-> (push.num == 2'd1 && push.r0.last_of_run))
    else $error("frame end result not single and last");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.num == 2'd2) |-> (!push.r0.last_of_run && push.r1.last_of_run))
    else $error("two-result run has wrong last marks");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (push.num != 2'd0 && push.r0.frame_end) |=> (kept_count == '0 && !drop_seen))
    else $error("frame state not cleared after end");

endmodule

`default_nettype wire

[hw/rtl/sfd_result_fifo.sv]
// Four-entry result queue: takes up to two results per cycle, gives one while out_ready is high.
// Depends on sfd_pkg.
`default_nettype none

module sfd_result_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sfd_pkg::res_pair_t push,
  output logic                    room_two,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sfd_pkg::res_t           out_res
);
  import sfd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_1;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_res   = slots[rd_ptr];
  assign room_two  = (count <= CNT_W'(DEPTH - 2));
  assign wr_ptr_1  = wr_ptr + PTR_W'(1);

  // storage
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.num == 2'd2) begin
      slots[wr_ptr_1] <= push.r1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push.num) - CNT_W'(pop);
    end
  end

  // checks
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (push.num != 2'd0) |-> (count <= CNT_W'(DEPTH - 2)))
    else $error("result queue written without room");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push.num == 2'd2 && !pop) |=> (count == $past(count) + CNT_W'(2)))
    else $error("result queue count lost a pair");

endmodule

`default_nettype wire
